>>> sv/rdse_pkg.sv
// ----------------------------------------------------------------------------
// rdse_pkg
// Types and constants shared by the row delta span encoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package rdse_pkg;

    localparam int ROW_WIDTH    = 240;
    localparam int ROW_TOTAL    = 320;
    localparam int GAP_LIMIT    = 3;
    localparam int ROW_W        = 9;
    localparam int COL_W        = 8;
    localparam int COLOUR_W     = 16;
    localparam int GAP_W        = 2;
    localparam int CNT_W        = 3;
    localparam int CANVAS_DEPTH = ROW_WIDTH * ROW_TOTAL;
    localparam int CANVAS_AW    = $clog2(CANVAS_DEPTH);
    localparam int CANVAS_DW    = COLOUR_W + 1;
    localparam int PADDR_W      = 3;

    localparam logic REG_DIFF_ENABLE = 1'b0;

    typedef struct packed {
        logic [ROW_W-1:0]    target_row;
        logic                painted;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                row_end;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]    out_row;
        logic [COL_W-1:0]    out_column;
        logic [COLOUR_W-1:0] out_colour;
        logic                span_first;
        logic                span_last;
        logic                batch_last;
    } t_out_item;

    typedef struct packed {
        logic                known;
        logic [COLOUR_W-1:0] colour;
    } t_canvas_word;

endpackage

`default_nettype wire

>>> sv/row_delta_span_encoder_unit.sv
// ----------------------------------------------------------------------------
// row_delta_span_encoder_unit
// Compares a pixel stream against a stored canvas and emits changed spans.
// ----------------------------------------------------------------------------
// A pixel item is accepted per cycle unless the input is stalled; its
// canvas word is read at acceptance and the decision is made in the next
// cycle. The single result port moves one result per cycle unless the output
// stalls, so an item holds the decision stage until all its results, up to
// five when a bridged gap is flushed, have moved. After reset a clearing
// pass writes all 76800 canvas words, one per cycle, accepting no pixel item.
`default_nettype none

module row_delta_span_encoder_unit
    import rdse_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data
);

    logic diff_en;

    rdse_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_diff_enable (diff_en)
    );

    // clearing pass
    logic                 r_clr_busy;
    logic [CANVAS_AW-1:0] r_clr_addr;

    // column tracking at acceptance
    logic [COL_W-1:0] r_col;

    // decision stage
    logic                 r_s1_valid;
    t_in_item             r_s1;
    logic [COL_W-1:0]     r_s1_col;
    logic                 r_s1_last;
    logic                 r_s1_inrange;
    logic [CANVAS_AW-1:0] r_s1_addr;
    logic [CNT_W-1:0]     r_k;
    logic                 r_fwd;
    logic [COLOUR_W-1:0]  r_fwd_colour;

    // span state
    logic                r_pend;
    logic [COLOUR_W-1:0] r_pend_colour;
    logic [COL_W-1:0]    r_pend_col;
    logic                r_pend_first;
    logic [COLOUR_W-1:0] r_gap [GAP_LIMIT];
    logic [GAP_W-1:0]    r_gap_len;

    logic      r_out_valid;
    t_out_item r_out;

    logic                 accept;
    logic                 in_range;
    logic                 in_last;
    logic [CANVAS_AW-1:0] rd_addr;
    t_canvas_word         rdata;
    logic                 kn;
    logic [COLOUR_W-1:0]  st;
    logic                 must_send;
    logic                 bridge;
    logic [CNT_W-1:0]     n_res;
    logic                 out_free;
    logic                 commit;
    logic                 emit;
    logic                 mem_we;
    logic [CANVAS_AW-1:0] mem_waddr;
    t_canvas_word         mem_wdata;
    logic                 commit_wr;
    t_out_item            res;
    logic [GAP_W-1:0]     gap_sel;

    assign in_range = i_in_data.target_row < ROW_W'(ROW_TOTAL);
    assign in_last  = i_in_data.row_end || (r_col >= COL_W'(ROW_WIDTH - 1));
    assign rd_addr  = CANVAS_AW'(i_in_data.target_row) * CANVAS_AW'(ROW_WIDTH)
                    + CANVAS_AW'(r_col);

    assign kn        = r_s1_inrange && (r_fwd || rdata.known);
    assign st        = r_fwd ? r_fwd_colour : rdata.colour;
    assign must_send = r_s1.painted && (!diff_en || !kn || st != r_s1.pixel_colour);
    assign bridge    = diff_en && kn && (r_gap_len < GAP_W'(GAP_LIMIT)) && !r_s1_last;

    always_comb begin
        n_res = '0;
        if (must_send && r_pend) begin
            n_res = CNT_W'(r_gap_len) + (r_s1_last ? CNT_W'(2) : CNT_W'(1));
        end else if (must_send) begin
            n_res = r_s1_last ? CNT_W'(1) : CNT_W'(0);
        end else if (r_pend) begin
            n_res = bridge ? CNT_W'(0) : CNT_W'(1);
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = r_s1_valid && (n_res != '0) && out_free;
    assign commit     = r_s1_valid && ((n_res == '0) || (emit && r_k == n_res - 1'b1));
    assign o_in_stall = r_clr_busy || (r_s1_valid && !commit);
    assign accept     = i_in_valid && !o_in_stall;
    assign commit_wr  = commit && must_send && r_s1_inrange;

    assign gap_sel = GAP_W'(r_k - 1'b1);

    always_comb begin
        res            = '0;
        res.out_row    = r_s1.target_row;
        res.batch_last = (r_k == n_res - 1'b1);
        if (must_send && r_pend) begin
            if (r_k == '0) begin
                res.out_column = r_pend_col;
                res.out_colour = r_pend_colour;
                res.span_first = r_pend_first;
            end else if (r_k <= CNT_W'(r_gap_len)) begin
                res.out_column = r_pend_col + COL_W'(r_k);
                res.out_colour = r_gap[gap_sel];
            end else begin
                res.out_column = r_s1_col;
                res.out_colour = r_s1.pixel_colour;
                res.span_last  = 1'b1;
            end
        end else if (must_send) begin
            res.out_column = r_s1_col;
            res.out_colour = r_s1.pixel_colour;
            res.span_first = 1'b1;
            res.span_last  = 1'b1;
        end else begin
            res.out_column = r_pend_col;
            res.out_colour = r_pend_colour;
            res.span_first = r_pend_first;
            res.span_last  = 1'b1;
        end
    end

    always_comb begin
        mem_we    = commit_wr;
        mem_waddr = r_s1_addr;
        mem_wdata = '{known: 1'b1, colour: r_s1.pixel_colour};
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end
    end

    rdse_ram #(
        .DEPTH (CANVAS_DEPTH),
        .WIDTH (CANVAS_DW),
        .AW    (CANVAS_AW)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            r_k         <= '0;
            r_fwd       <= 1'b0;
            r_pend      <= 1'b0;
            r_gap_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CANVAS_AW'(CANVAS_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (emit && !commit) begin
                r_k <= r_k + 1'b1;
            end else if (commit) begin
                r_k <= '0;
            end

            // a row end never bridges, and a held span is cleared with its gap
            if (commit) begin
                if (must_send) begin
                    r_gap_len <= '0;
                    r_pend    <= !r_s1_last;
                end else if (r_pend) begin
                    if (bridge) begin
                        r_gap_len <= r_gap_len + 1'b1;
                    end else begin
                        r_pend    <= 1'b0;
                        r_gap_len <= '0;
                    end
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                r_col      <= in_last ? '0 : r_col + 1'b1;
                r_fwd      <= commit_wr && (r_s1_addr == rd_addr);
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
        if (accept) begin
            r_s1         <= i_in_data;
            r_s1_col     <= r_col;
            r_s1_last    <= in_last;
            r_s1_inrange <= in_range;
            r_s1_addr    <= rd_addr;
            r_fwd_colour <= r_s1.pixel_colour;
        end
        if (commit && must_send) begin
            r_pend_colour <= r_s1.pixel_colour;
            r_pend_col    <= r_s1_col;
            r_pend_first  <= !r_pend;
        end
        if (commit && !must_send && r_pend && bridge) begin
            r_gap[r_gap_len] <= st;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> sv/rdse_ram.sv
// ----------------------------------------------------------------------------
// rdse_ram
// Simple dual port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdse_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/rdse_regs.sv
// ----------------------------------------------------------------------------
// rdse_regs
// APB configuration register holding the differencing enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rdse_regs
    import rdse_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output logic                    o_diff_enable
);

    logic r_diff_enable;
    logic w_index;

    assign w_index       = paddr[2];
    assign pready        = 1'b1;
    assign o_diff_enable = r_diff_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_enable <= 1'b1;
        end else if (psel && penable && pwrite && w_index == REG_DIFF_ENABLE) begin
            r_diff_enable <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_index == REG_DIFF_ENABLE) begin
            prdata = {31'b0, r_diff_enable};
        end
    end

endmodule

`default_nettype wire

>>> tb/row_delta_span_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// row_delta_span_encoder_unit_tb
// Drives pixel rows into the encoder and predicts the emitted span pixels
// from an own canvas model, under random idling on both sides, with
// differencing both enabled and disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module row_delta_span_encoder_unit_tb;
    import rdse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;

    localparam logic [PADDR_W-1:0] ADDR_DIFF_ENABLE = PADDR_W'(REG_DIFF_ENABLE) << 2;

    row_delta_span_encoder_unit uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // encoder model state
    logic [COLOUR_W-1:0] cv_colour [CANVAS_DEPTH];
    bit                  cv_known [CANVAS_DEPTH];
    int unsigned         col_next;
    bit                  held_valid;
    logic [COLOUR_W-1:0] held_colour;
    logic [COL_W-1:0]    held_column;
    bit                  held_first;
    logic [COLOUR_W-1:0] gap_col [GAP_LIMIT];
    int unsigned         gap_len;
    bit                  diff_on;

    t_out_item span_q[$];
    int        mismatches;
    bit        quiet;
    int        sent;

    task automatic push_span(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic [COLOUR_W-1:0] colour, input bit first,
                             input bit last, inout t_out_item batch[$]);
        t_out_item r;
        r = '{out_row: row, out_column: col, out_colour: colour,
              span_first: first, span_last: last, batch_last: 1'b0};
        batch.push_back(r);
    endtask

    task automatic encode_pixel(input t_in_item it, output t_out_item batch[$]);
        int unsigned col, idx;
        bit          in_range, kn, send, last;
        logic [COLOUR_W-1:0] st;
        batch = {};
        col = col_next;
        in_range = it.target_row < ROW_TOTAL && col < ROW_WIDTH;
        idx = in_range ? it.target_row * ROW_WIDTH + col : 0;
        kn = in_range && cv_known[idx];
        st = kn ? cv_colour[idx] : '0;
        send = it.painted && (!diff_on || !kn || st != it.pixel_colour);
        last = it.row_end || col >= ROW_WIDTH - 1;
        if (send) begin
            if (held_valid) begin
                push_span(it.target_row, held_column, held_colour, held_first, 0, batch);
                for (int i = 0; i < gap_len; i++)
                    push_span(it.target_row, held_column + COL_W'(i + 1), gap_col[i],
                              0, 0, batch);
            end
            held_first = !held_valid;
            if (in_range) begin
                cv_colour[idx] = it.pixel_colour;
                cv_known[idx] = 1'b1;
            end
            gap_len = 0;
            held_colour = it.pixel_colour;
            held_column = COL_W'(col);
            held_valid = 1'b1;
            if (last)
                push_span(it.target_row, held_column, held_colour, held_first, 1, batch);
        end else if (held_valid) begin
            if (diff_on && kn && gap_len < GAP_LIMIT && !last) begin
                gap_col[gap_len] = st;
                gap_len++;
            end else begin
                push_span(it.target_row, held_column, held_colour, held_first, 1, batch);
                held_valid = 1'b0;
                gap_len = 0;
            end
        end
        if (last) begin
            col_next = 0;
            held_valid = 1'b0;
            gap_len = 0;
        end else begin
            col_next = col + 1;
        end
        if (batch.size() > 0)
            batch[batch.size()-1].batch_last = 1'b1;
    endtask

    function automatic bit idle_roll();
        return !quiet && $urandom_range(99) < 16;
    endfunction

    task automatic send_pixel(input t_in_item it, input bit check_first = 0,
                              input t_out_item first_span = '0);
        t_out_item batch[$];
        t_out_item got;
        while (idle_roll()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        encode_pixel(it, batch);
        got = '0;
        if (batch.size() > 0) got = batch[0];
        if (check_first && (batch.size() == 0 || got !== first_span)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row %0d: expected %h actual %h", sent, first_span, got);
        end
        foreach (batch[i]) span_q.push_back(batch[i]);
        sent++;
    endtask

    task automatic write_diff(input bit v);
        i_in_valid <= 1'b0;
        wait (span_q.size() == 0);
        repeat (12) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_DIFF_ENABLE;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        diff_on = v;
    endtask

    // receive side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (span_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected span pixel %p", o_out_data);
            end else begin
                if (o_out_data !== span_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected %p actual %p", span_q[0], o_out_data);
                end
                void'(span_q.pop_front());
            end
        end
        i_out_stall <= idle_roll();
    end

    typedef struct {
        t_in_item  it;
        bit        chk;
        t_out_item exp_span;
    } t_table_row;

    function automatic t_in_item px(int row, bit p, int colour, bit e);
        t_in_item t;
        t.target_row = ROW_W'(row);
        t.painted = p;
        t.pixel_colour = COLOUR_W'(colour);
        t.row_end = e;
        return t;
    endfunction

    function automatic logic [COLOUR_W-1:0] pick_colour(int unsigned row, int unsigned col);
        int unsigned idx;
        idx = row * ROW_WIDTH + col;
        if (row < ROW_TOTAL && col < ROW_WIDTH && cv_known[idx] && $urandom_range(99) < 65)
            return cv_colour[idx];
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001 << $urandom_range(15);
            default: return COLOUR_W'($urandom);
        endcase
    endfunction

    task automatic random_row(input bit full);
        int unsigned row, len;
        bit          e;
        row = $urandom_range(99) < 8 ? $urandom_range(511, 320) : $urandom_range(5);
        if ($urandom_range(99) < 4) row = $urandom_range(319);
        len = full ? ROW_WIDTH : $urandom_range(12, 1);
        for (int c = 0; c < len; c++) begin
            e = (c == len - 1) && !(full && $urandom_range(1));
            if ($urandom_range(99) < 3) row = $urandom_range(511);
            send_pixel(px(row, $urandom_range(99) < 85, pick_colour(row, c), e));
        end
    endtask

    t_table_row dir_tab[] = '{
        '{px(0, 1, 16'hFFFF, 1), 1, '{9'd0, 8'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1}},
        '{px(0, 1, 16'hFFFF, 1), 0, '0},
        '{px(2, 1, 16'h0000, 0), 0, '0},
        '{px(2, 1, 16'h0000, 0), 1, '{9'd2, 8'd0, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{px(2, 1, 16'h0000, 0), 0, '0},
        '{px(2, 1, 16'h0000, 0), 0, '0},
        '{px(2, 1, 16'h0000, 1), 0, '0},
        '{px(2, 1, 16'h8001, 0), 0, '0},
        '{px(2, 0, 16'h0000, 0), 0, '0},
        '{px(2, 1, 16'h0000, 0), 0, '0},
        '{px(2, 1, 16'h7FFE, 0), 0, '0},
        '{px(2, 1, 16'h0000, 1), 0, '0},
        '{px(319, 1, 16'h5555, 1), 1, '{9'd319, 8'd0, 16'h5555, 1'b1, 1'b1, 1'b1}},
        '{px(320, 1, 16'hAAAA, 1), 1, '{9'd320, 8'd0, 16'hAAAA, 1'b1, 1'b1, 1'b1}},
        '{px(511, 0, 16'hFFFF, 1), 0, '0},
        '{px(5, 1, 16'h1234, 0), 0, '0},
        '{px(6, 1, 16'h4321, 1), 1, '{9'd6, 8'd0, 16'h1234, 1'b1, 1'b0, 1'b0}},
        '{px(2, 0, 16'h0000, 0), 0, '0},
        '{px(2, 1, 16'h8001, 0), 0, '0},
        '{px(2, 0, 16'h0000, 0), 0, '0},
        '{px(2, 0, 16'h0000, 1), 0, '0}
    };

    initial begin
        int wait_cycles;
        for (int i = 0; i < CANVAS_DEPTH; i++) cv_known[i] = 1'b0;
        col_next = 0;
        held_valid = 1'b0;
        gap_len = 0;
        diff_on = 1'b1;
        mismatches = 0;
        sent = 0;
        quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_diff(1'b1);
        foreach (dir_tab[i])
            send_pixel(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].exp_span);
        for (int ph = 0; ph < 4; ph++) begin
            write_diff(ph[0]);
            // full row with no idling on either side
            if (ph == 1) begin
                quiet = 1'b1;
                random_row(1'b1);
                quiet = 1'b0;
            end
            sent = 0;
            while (sent < 40)
                random_row(1'b0);
        end
        write_diff(1'b1);
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (span_q.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && span_q.size() == 0)
            $display("row_delta_span_encoder_unit: match");
        else
            $display("row_delta_span_encoder_unit: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("row_delta_span_encoder_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> row_delta_span_encoder_unit.f
sv/rdse_pkg.sv
sv/rdse_ram.sv
sv/rdse_regs.sv
sv/row_delta_span_encoder_unit.sv
tb/row_delta_span_encoder_unit_tb.sv
